@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, skipped while reset is held
`define BCA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("bitmap allocator check failed");

// Check a property on the rising clock, reset cycles included
`define BCA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bitmap allocator check failed");

`endif

@@ design/bca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bca_pkg;

    // Operation codes carried by a transaction
    typedef enum logic [1:0] {
        ACT_FIND   = 2'd0,
        ACT_USE    = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_FORMAT = 2'd3
    } t_action;

    localparam logic [7:0] FULL_BYTE  = 8'hff;
    localparam logic [7:0] FIRST_MASK = 8'h80;
    // Bytes reachable by a 12-bit cluster number
    localparam int unsigned SCAN_SPAN = 512;
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned IDX_W     = 12;

endpackage

`default_nettype wire

@@ design/bca_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/bitmap_cluster_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Free-space bitmap allocator, one bit per cluster (MSB-first in each byte, 1 = used),
// held in a single-port-read byte memory of MAP_BYTES entries. A transaction is taken
// when i_start is high and o_busy is low; its result appears on o_found/o_result_index
// for exactly one cycle with o_done, and the receiver cannot stall it. Mark-used and
// mark-free read the cluster's byte and write it back in ST_MARK; a cluster outside the
// map gives its result with o_found low and no memory access. Find-free reads one byte
// per cycle from the first byte on until a byte with a free bit, which it marks used,
// or until min(MAP_BYTES, 512) bytes are read. Format rewrites every byte, one per
// cycle. After reset a clearing pass writes zero to every byte with o_busy high;
// configuration writes are taken throughout.
module bitmap_cluster_allocator_top #(
    parameter int MAP_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [11:0] i_cluster_index,
    output logic             o_done,
    output logic             o_found,
    output logic [11:0]      o_result_index,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_wdata
);

    localparam int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int EW         = (AW + 4 > 14) ? AW + 4 : 14;
    localparam int SCAN_BYTES = (MAP_BYTES < int'(bca_pkg::SCAN_SPAN)) ?
                                MAP_BYTES : int'(bca_pkg::SCAN_SPAN);
    localparam logic [EW-1:0] MAP_BITS  = EW'(MAP_BYTES * 8);
    localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);
    localparam logic [AW-1:0] LAST_SCAN = AW'(SCAN_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_MARK
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_addr, n_addr;
    logic [12:0]           r_count, n_count;
    logic                  r_fmt, n_fmt;
    logic                  r_use, n_use;
    logic [11:0]           r_index, n_index;
    logic                  r_done, n_done;
    logic                  r_found, n_found;
    logic [11:0]           r_result, n_result;
    logic [12:0]           r_reserved;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [7:0]            ram_wdata, ram_rdata;

    logic                  accept;
    bca_pkg::t_action      act;
    logic [2:0]            zero_pos;
    logic [EW-1:0]         sweep_lo, sweep_cnt, idx_ext, hit_ext;
    logic [7:0]            sweep_val;
    logic [2:0]            part_bits;

    bca_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept  = i_start && (r_state == ST_IDLE);
    assign act     = bca_pkg::t_action'(i_action);
    assign idx_ext = EW'(i_cluster_index);

    // Locate the first free bit of the byte just read, MSB first
    always_comb begin
        zero_pos = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (!ram_rdata[7 - b]) begin
                zero_pos = 3'(b);
            end
        end
    end

    assign hit_ext = (EW'(r_addr) << 3) | EW'(zero_pos);

    // Build the byte that format leaves at the current sweep address
    assign sweep_lo  = EW'(r_addr) << 3;
    assign sweep_cnt = EW'(r_count);
    assign part_bits = 3'(sweep_cnt - sweep_lo);
    always_comb begin
        if (sweep_cnt >= sweep_lo + EW'(8)) begin
            sweep_val = bca_pkg::FULL_BYTE;
        end else if (sweep_cnt > sweep_lo) begin
            sweep_val = ~(bca_pkg::FULL_BYTE >> part_bits);
        end else begin
            sweep_val = 8'h00;
        end
    end

    // Sequence the read-modify-write of each operation
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_count   = r_count;
        n_fmt     = r_fmt;
        n_use     = r_use;
        n_index   = r_index;
        n_done    = 1'b0;
        n_found   = r_found;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = sweep_val;
        ram_re    = 1'b0;
        ram_raddr = r_addr + AW'(1);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_index = i_cluster_index;
                    n_use   = (act == bca_pkg::ACT_USE);
                    n_addr  = '0;
                    case (act)
                        bca_pkg::ACT_FIND: begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_state   = ST_SCAN;
                        end
                        bca_pkg::ACT_USE, bca_pkg::ACT_FREE: begin
                            if (idx_ext < MAP_BITS) begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(i_cluster_index >> 3);
                                n_state   = ST_MARK;
                            end else begin
                                n_done   = 1'b1;
                                n_found  = 1'b0;
                                n_result = i_cluster_index;
                            end
                        end
                        bca_pkg::ACT_FORMAT: begin
                            n_count = (EW'(r_reserved) < MAP_BITS) ?
                                      r_reserved : 13'(MAP_BITS);
                            n_fmt   = 1'b1;
                            n_state = ST_SWEEP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                ram_we = 1'b1;
                if (r_addr == LAST_BYTE) begin
                    n_state = ST_IDLE;
                    if (r_fmt) begin
                        n_done   = 1'b1;
                        n_found  = 1'b1;
                        n_result = '0;
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_SCAN: begin
                if (ram_rdata != bca_pkg::FULL_BYTE) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (bca_pkg::FIRST_MASK >> zero_pos);
                    n_done    = 1'b1;
                    n_found   = 1'b1;
                    n_result  = hit_ext[11:0];
                    n_state   = ST_IDLE;
                end else if (r_addr == LAST_SCAN) begin
                    n_done   = 1'b1;
                    n_found  = 1'b0;
                    n_result = '0;
                    n_state  = ST_IDLE;
                end else begin
                    ram_re = 1'b1;
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_index >> 3);
                ram_wdata = r_use ? (ram_rdata | (bca_pkg::FIRST_MASK >> r_index[2:0]))
                                  : (ram_rdata & ~(bca_pkg::FIRST_MASK >> r_index[2:0]));
                n_done    = 1'b1;
                n_found   = 1'b1;
                n_result  = r_index;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, sweep position and the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_addr  <= '0;
            r_count <= '0;
            r_fmt   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_fmt   <= n_fmt;
            r_done  <= n_done;
        end
        r_use    <= n_use;
        r_index  <= n_index;
        r_found  <= n_found;
        r_result <= n_result;
    end

    // Capture the reserved count written over the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= 13'd1;
        end else if (i_cfg_we) begin
            r_reserved <= i_cfg_wdata;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_found        = r_found;
    assign o_result_index = r_result;

endmodule

`default_nettype wire

@@ design/bca_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bca_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_done,
    input wire logic        o_found,
    input wire logic [11:0] o_result_index
);

    logic        take;
    logic [12:0] shown_result;
    assign take         = i_start && !o_busy;
    assign shown_result = {o_found, o_result_index};

    // A result is shown only once the block is free again
    `BCA_ASSERT(a_done_not_busy, i_clk, i_rst_n, o_done |-> !o_busy)
    // An accepted transaction keeps the block busy or finishes at once
    `BCA_ASSERT(a_take_progress, i_clk, i_rst_n, take |=> (o_busy || o_done))
    // No result appears out of an idle cycle with nothing accepted
    `BCA_ASSERT(a_no_spurious, i_clk, i_rst_n, (!o_busy && !i_start) |=> !o_done)
    // A shown result carries known values
    `BCA_ASSERT(a_result_known, i_clk, i_rst_n, o_done |-> !$isunknown(shown_result))
    // Reset starts the clearing pass
    `BCA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (o_busy && !o_done))

endmodule

bind bitmap_cluster_allocator_top bca_checker u_bca_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_found        (o_found),
    .o_result_index (o_result_index)
);

`default_nettype wire
